[hdl/lrwp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lidar ray projector package
// Shared types, constants and the CORDIC arctangent table of the lidar ray
// to world point unit.
// ----------------------------------------------------------------------------
package lrwp_pkg;

  // Scan and rotation settings.
  localparam int MAX_RAYS     = 4096;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN    = 24;

  // Field widths.
  localparam int RANGE_W = 16;
  localparam int ANGLE_W = 16;
  localparam int POS_W   = 24;
  localparam int INDEX_W = 12;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 4;
  localparam int STEP_W  = 5;

  // Datapath widths: rotation vector, residual angle, pose sum.
  localparam int XW   = 35;
  localparam int ZW   = 34;
  localparam int RXW  = XW - 16;
  localparam int SUMW = POS_W + 2;

  // Highest ray index reported.
  localparam int RAY_CAP_INT = (MAX_RAYS - 1) < 4095 ? (MAX_RAYS - 1) : 4095;
  localparam logic [INDEX_W-1:0] RAY_CAP = INDEX_W'(RAY_CAP_INT);

  // Last rotation step index.
  localparam int STEPS_USED = CORDIC_STEPS < TABLE_LEN ? CORDIC_STEPS : TABLE_LEN;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS_USED - 1);

  // Phase mask that keeps the top ANGLE_BITS bits of a 32-bit turn.
  localparam logic [31:0] PH_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

  // Inverse CORDIC gain, unsigned Q0.32.
  localparam logic [31:0] GAIN_Q32 = 32'h9B74_EDA8;

  // Position range.
  localparam logic signed [SUMW-1:0] POS_MAX = SUMW'(8388607);
  localparam logic signed [SUMW-1:0] POS_MIN = -SUMW'(8388608);

  // Register reset values.
  localparam logic [RANGE_W-1:0] RANGE_HIGH_RST = 16'hFFFF;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_START = 4'd0,
    REG_ANGLE_STEP  = 4'd1,
    REG_RANGE_LOW   = 4'd2,
    REG_RANGE_HIGH  = 4'd3,
    REG_POSE_X      = 4'd4,
    REG_POSE_Y      = 4'd5,
    REG_POSE_YAW    = 4'd6,
    REG_PROJ_ENABLE = 4'd7
  } cfg_reg_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MULT,
    ST_ROT,
    ST_DONE
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              mult;
    logic              step;
    logic              finish;
    logic [STEP_W-1:0] step_idx;
  } ctrl_cmd_t;

  // Arctangent of 2^-i in 2^32 units per turn.
  function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'h2000_0000;
      5'd1:    val = 32'h12E4_051E;
      5'd2:    val = 32'h09FB_385B;
      5'd3:    val = 32'h0511_11D4;
      5'd4:    val = 32'h028B_0D43;
      5'd5:    val = 32'h0145_D7E1;
      5'd6:    val = 32'h00A2_F61E;
      5'd7:    val = 32'h0051_7C55;
      5'd8:    val = 32'h0028_BE53;
      5'd9:    val = 32'h0014_5F2F;
      5'd10:   val = 32'h000A_2F98;
      5'd11:   val = 32'h0005_17CC;
      5'd12:   val = 32'h0002_8BE6;
      5'd13:   val = 32'h0001_45F3;
      5'd14:   val = 32'h0000_A2FA;
      5'd15:   val = 32'h0000_517D;
      5'd16:   val = 32'h0000_28BE;
      5'd17:   val = 32'h0000_145F;
      5'd18:   val = 32'h0000_0A30;
      5'd19:   val = 32'h0000_0518;
      5'd20:   val = 32'h0000_028C;
      5'd21:   val = 32'h0000_0146;
      5'd22:   val = 32'h0000_00A3;
      5'd23:   val = 32'h0000_0051;
      default: val = 32'h0000_0000;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

[hdl/lrwp_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lidar ray projector controller
// Sequences one ray through load, gain multiply, CORDIC rotation and the
// final pose sum, and owns the output word's valid flag.
// ----------------------------------------------------------------------------
module lrwp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output lrwp_pkg::ctrl_cmd_t    cmd_o
);

  lrwp_pkg::ctrl_state_e              state_q, state_d;
  logic [lrwp_pkg::STEP_W-1:0]        step_q, step_d;
  logic                               out_valid_q, out_valid_d;

  // State, step counter and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lrwp_pkg::ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    cmd_o        = '0;
    cmd_o.step_idx = step_q;
    in_ready_o   = 1'b0;
    case (state_q)
      lrwp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = lrwp_pkg::ST_MULT;
        end
      end
      lrwp_pkg::ST_MULT: begin
        cmd_o.mult = 1'b1;
        step_d     = '0;
        state_d    = lrwp_pkg::ST_ROT;
      end
      lrwp_pkg::ST_ROT: begin
        cmd_o.step = 1'b1;
        step_d     = step_q + 1'b1;
        if (step_q == lrwp_pkg::STEP_LAST) begin
          state_d = lrwp_pkg::ST_DONE;
        end
      end
      lrwp_pkg::ST_DONE: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = lrwp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lrwp_pkg::ST_IDLE;
      end
    endcase
  end

  // The output word stays valid until taken.
  always_comb begin
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

[hdl/lrwp_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lidar ray projector datapath
// Configuration registers, ray index and angle tracking, the gain multiply,
// a shared CORDIC rotation stage and the saturating pose sum.
// ----------------------------------------------------------------------------
module lrwp_datapath (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [lrwp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [lrwp_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  wire logic [lrwp_pkg::RANGE_W-1:0]         range_mm_i,
  input  wire logic                                 range_finite_i,
  input  wire logic                                 first_ray_i,
  input  wire logic                                 last_ray_i,
  input  wire lrwp_pkg::ctrl_cmd_t                  cmd_i,
  output logic                                      hit_valid_o,
  output logic signed [lrwp_pkg::POS_W-1:0]         hit_x_mm_o,
  output logic signed [lrwp_pkg::POS_W-1:0]         hit_y_mm_o,
  output logic [lrwp_pkg::INDEX_W-1:0]              ray_index_o,
  output logic                                      scan_end_o
);

  localparam int XW   = lrwp_pkg::XW;
  localparam int ZW   = lrwp_pkg::ZW;
  localparam int RXW  = lrwp_pkg::RXW;
  localparam int SUMW = lrwp_pkg::SUMW;
  localparam int PW   = lrwp_pkg::POS_W;

  localparam logic signed [31:0] QTR_POS = 32'sh4000_0000;
  localparam logic signed [31:0] QTR_NEG = -QTR_POS;

  // Configuration registers.
  logic [lrwp_pkg::ANGLE_W-1:0] angle_start_q, angle_step_q, pose_yaw_q;
  logic [lrwp_pkg::RANGE_W-1:0] range_low_q, range_high_q;
  logic [PW-1:0]                pose_x_q, pose_y_q;
  logic                         proj_en_q;

  // Scan tracking state.
  logic [lrwp_pkg::INDEX_W-1:0] ray_cnt_q, ray_cnt_d;
  logic [lrwp_pkg::ANGLE_W-1:0] ray_ang_q, ray_ang_d;

  // Per-ray working registers.
  logic [lrwp_pkg::RANGE_W-1:0] range_q;
  logic [lrwp_pkg::ANGLE_W-1:0] world_q;
  logic                         accept_q;
  logic                         last_q;
  logic signed [XW-1:0]         x_q, y_q;
  logic signed [ZW-1:0]         z_q;

  // Output word registers.
  logic                         hit_valid_q;
  logic signed [PW-1:0]         hit_x_q, hit_y_q;
  logic [lrwp_pkg::INDEX_W-1:0] index_q;
  logic                         scan_end_q;

  // Saturate a pose sum to the position range.
  function automatic logic signed [PW-1:0] sat_pos(input logic signed [SUMW-1:0] v);
    logic signed [PW-1:0] r;
    if (v > lrwp_pkg::POS_MAX) begin
      r = PW'(lrwp_pkg::POS_MAX);
    end else if (v < lrwp_pkg::POS_MIN) begin
      r = PW'(lrwp_pkg::POS_MIN);
    end else begin
      r = v[PW-1:0];
    end
    return r;
  endfunction

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_start_q <= '0;
      angle_step_q  <= '0;
      range_low_q   <= '0;
      range_high_q  <= lrwp_pkg::RANGE_HIGH_RST;
      pose_x_q      <= '0;
      pose_y_q      <= '0;
      pose_yaw_q    <= '0;
      proj_en_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lrwp_pkg::REG_ANGLE_START: angle_start_q <= cfg_wdata_i[lrwp_pkg::ANGLE_W-1:0];
        lrwp_pkg::REG_ANGLE_STEP:  angle_step_q  <= cfg_wdata_i[lrwp_pkg::ANGLE_W-1:0];
        lrwp_pkg::REG_RANGE_LOW:   range_low_q   <= cfg_wdata_i[lrwp_pkg::RANGE_W-1:0];
        lrwp_pkg::REG_RANGE_HIGH:  range_high_q  <= cfg_wdata_i[lrwp_pkg::RANGE_W-1:0];
        lrwp_pkg::REG_POSE_X:      pose_x_q      <= cfg_wdata_i[PW-1:0];
        lrwp_pkg::REG_POSE_Y:      pose_y_q      <= cfg_wdata_i[PW-1:0];
        lrwp_pkg::REG_POSE_YAW:    pose_yaw_q    <= cfg_wdata_i[lrwp_pkg::ANGLE_W-1:0];
        lrwp_pkg::REG_PROJ_ENABLE: proj_en_q     <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // Ray index and local angle advance on every ray, the index stopping at RAY_CAP; a first ray restarts them.
  always_comb begin
    if (first_ray_i) begin
      ray_cnt_d = '0;
      ray_ang_d = angle_start_q;
    end else begin
      ray_cnt_d = (ray_cnt_q < lrwp_pkg::RAY_CAP) ? ray_cnt_q + 1'b1 : lrwp_pkg::RAY_CAP;
      ray_ang_d = ray_ang_q + angle_step_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ray_cnt_q <= '0;
      ray_ang_q <= '0;
    end else if (cmd_i.load) begin
      ray_cnt_q <= ray_cnt_d;
      ray_ang_q <= ray_ang_d;
    end
  end

  // Gain multiply and quadrant fold of the world angle.
  logic [47:0]          prod;
  logic signed [XW-1:0] x_init;
  logic [31:0]          ph, ph_fold;
  logic                 fold;

  always_comb begin
    prod    = 48'(range_q) * 48'(lrwp_pkg::GAIN_Q32);
    x_init  = signed'(XW'(prod[47:16]));
    ph      = {world_q, 16'h0000} & lrwp_pkg::PH_MASK;
    fold    = (signed'(ph) > QTR_POS) || (signed'(ph) < QTR_NEG);
    ph_fold = fold ? ph + 32'h8000_0000 : ph;
  end

  // One CORDIC rotation step per cycle.
  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] atan_z;

  always_comb begin
    xs     = x_q >>> cmd_i.step_idx;
    ys     = y_q >>> cmd_i.step_idx;
    atan_z = signed'(ZW'(lrwp_pkg::atan_entry(cmd_i.step_idx)));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      range_q  <= range_mm_i;
      world_q  <= ray_ang_d + pose_yaw_q;
      last_q   <= last_ray_i;
      accept_q <= proj_en_q && range_finite_i &&
                  (range_mm_i >= range_low_q) && (range_mm_i <= range_high_q);
    end
    if (cmd_i.mult) begin
      x_q <= fold ? -x_init : x_init;
      y_q <= '0;
      z_q <= ZW'(signed'(ph_fold));
    end else if (cmd_i.step) begin
      if (!z_q[ZW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_z;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_z;
      end
    end
  end

  // Round to whole millimetres and add the pose.
  logic signed [XW-1:0]   x_rnd, y_rnd;
  logic signed [RXW-1:0]  dx, dy;
  logic signed [SUMW-1:0] sum_x, sum_y;

  always_comb begin
    x_rnd = x_q + XW'(32768);
    y_rnd = y_q + XW'(32768);
    dx    = x_rnd[XW-1:16];
    dy    = y_rnd[XW-1:16];
    sum_x = SUMW'(signed'(pose_x_q)) + SUMW'(dx);
    sum_y = SUMW'(signed'(pose_y_q)) + SUMW'(dy);
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      hit_valid_q <= accept_q;
      hit_x_q     <= accept_q ? sat_pos(sum_x) : '0;
      hit_y_q     <= accept_q ? sat_pos(sum_y) : '0;
      index_q     <= ray_cnt_q;
      scan_end_q  <= last_q;
    end
  end

  assign hit_valid_o = hit_valid_q;
  assign hit_x_mm_o  = hit_x_q;
  assign hit_y_mm_o  = hit_y_q;
  assign ray_index_o = index_q;
  assign scan_end_o  = scan_end_q;

endmodule
`default_nettype wire

[hdl/lidar_ray_to_world_point_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lidar ray to world point unit
// Projects each lidar ray range to a world hit point from the robot pose.
// ----------------------------------------------------------------------------
// Each ray is loaded at the edge that accepts it, which also updates the ray
// index and angle. Its result word reaches the output register after the gain
// multiply, one rotation step per CORDIC step in a single shared CORDIC stage,
// and rounding with the saturating pose sum. The unit works on one ray at a
// time, so it takes no new ray until the previous result is in the output
// register. The next ray is accepted as soon as that result is there; the
// register holds it until the consumer takes it, and while it is still full,
// the unit waits in its final cycle. Configuration registers must be written
// through the plain write port only while no ray is in flight; the unit does
// not enforce this.
// ----------------------------------------------------------------------------
module lidar_ray_to_world_point_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Configuration write port.
  input  wire logic                                 cfg_we_i,
  input  wire logic [lrwp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [lrwp_pkg::CFG_W-1:0]           cfg_wdata_i,
  // Ray input channel.
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [lrwp_pkg::RANGE_W-1:0]         range_mm_i,
  input  wire logic                                 range_finite_i,
  input  wire logic                                 first_ray_i,
  input  wire logic                                 last_ray_i,
  // Hit output channel.
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic                                      hit_valid_o,
  output logic signed [lrwp_pkg::POS_W-1:0]         hit_x_mm_o,
  output logic signed [lrwp_pkg::POS_W-1:0]         hit_y_mm_o,
  output logic [lrwp_pkg::INDEX_W-1:0]              ray_index_o,
  output logic                                      scan_end_o
);

  lrwp_pkg::ctrl_cmd_t cmd;

  // Sequencer.
  lrwp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Arithmetic and registers.
  lrwp_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .range_mm_i     (range_mm_i),
    .range_finite_i (range_finite_i),
    .first_ray_i    (first_ray_i),
    .last_ray_i     (last_ray_i),
    .cmd_i          (cmd),
    .hit_valid_o    (hit_valid_o),
    .hit_x_mm_o     (hit_x_mm_o),
    .hit_y_mm_o     (hit_y_mm_o),
    .ray_index_o    (ray_index_o),
    .scan_end_o     (scan_end_o)
  );

endmodule
`default_nettype wire

[hdl/lrwp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lidar ray projector checker
// Port-level assertions on the lidar ray to world point unit.
// ----------------------------------------------------------------------------
module lrwp_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 in_valid_i,
  input wire logic                                 in_ready_o,
  input wire logic                                 out_valid_o,
  input wire logic                                 out_ready_i,
  input wire logic                                 hit_valid_o,
  input wire logic signed [lrwp_pkg::POS_W-1:0]    hit_x_mm_o,
  input wire logic signed [lrwp_pkg::POS_W-1:0]    hit_y_mm_o,
  input wire logic [lrwp_pkg::INDEX_W-1:0]         ray_index_o,
  input wire logic                                 scan_end_o
);

  // A stalled output word stays valid.
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its payload.
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(hit_x_mm_o) && $stable(hit_y_mm_o) &&
    $stable(ray_index_o) && $stable(hit_valid_o) && $stable(scan_end_o))
    else $error("output word changed while stalled");

  // A rejected ray reports a zero hit point.
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_valid_o |-> hit_x_mm_o == '0 && hit_y_mm_o == '0)
    else $error("rejected ray carries a hit point");

  // The unit is busy through the gain multiply and the first rotation step after taking a ray.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("ray accepted during rotation");

endmodule

bind lidar_ray_to_world_point_unit lrwp_checker u_lrwp_checker (.*);
`default_nettype wire

[dv/lidar_ray_to_world_point_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar ray to world point unit testbench
// Sends lidar ray words through the valid/ready input and checks every hit
// word against a cycle-free CORDIC predictor that tracks the ray index, ray
// angle and register settings. Directed rays cover quadrant boundaries, the
// range window, saturation and unknown register writes; a long unbroken scan
// and random scans under random idling and a long receiver hold-off follow.
// ----------------------------------------------------------------------------
module lidar_ray_to_world_point_unit_test;
  import lrwp_pkg::*;

  localparam int     NUM_REGS        = 8;
  localparam int     DRAIN_CYCLES    = CORDIC_STEPS + 8;
  localparam int     RANDOM_RAYS     = 1500;
  localparam int     LONG_SCAN_RAYS  = 250;
  localparam int     HOLD_OFF_CYCLES = 400;
  localparam int     IDLE_PERCENT    = 37;
  localparam int     REPORT_LIMIT    = 10;
  localparam longint QUARTER_TURN    = 64'sh4000_0000;
  localparam longint POS_TOP         = 64'sd8388607;
  localparam longint POS_BOTTOM      = -64'sd8388608;

  typedef struct packed {
    logic [RANGE_W-1:0] rng;
    logic               finite;
    logic               is_first;
    logic               is_last;
  } ray_t;

  typedef struct packed {
    logic               hit_valid;
    logic [POS_W-1:0]   hit_x;
    logic [POS_W-1:0]   hit_y;
    logic [INDEX_W-1:0] index;
    logic               scan_end;
  } hit_t;

  // Clock and block ports.
  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [RANGE_W-1:0]   range_mm_i;
  logic                 range_finite_i;
  logic                 first_ray_i;
  logic                 last_ray_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 hit_valid_o;
  logic signed [POS_W-1:0] hit_x_mm_o;
  logic signed [POS_W-1:0] hit_y_mm_o;
  logic [INDEX_W-1:0]   ray_index_o;
  logic                 scan_end_o;

  // Mirror of the register settings and of the scan tracking state.
  logic [ANGLE_W-1:0]      scan_angle_start = '0;
  logic [ANGLE_W-1:0]      scan_angle_step  = '0;
  logic [RANGE_W-1:0]      window_low       = '0;
  logic [RANGE_W-1:0]      window_high      = RANGE_HIGH_RST;
  logic signed [POS_W-1:0] robot_x          = '0;
  logic signed [POS_W-1:0] robot_y          = '0;
  logic [ANGLE_W-1:0]      robot_yaw        = '0;
  logic                    projecting       = 1'b0;
  logic [INDEX_W-1:0]      ray_pos          = '0;
  logic [ANGLE_W-1:0]      ray_heading      = '0;

  // Arctangent of 2^-i, 2^32 units per turn.
  logic [31:0] atan_turn [TABLE_LEN] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
    32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
    32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
    32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
  };

  hit_t pending_hits[$];
  int   mismatch_count    = 0;
  int   checked_words     = 0;
  bit   steady_flow       = 1'b0;
  int   hold_off_request  = 0;
  int   hold_span;

  lidar_ray_to_world_point_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .range_mm_i     (range_mm_i),
    .range_finite_i (range_finite_i),
    .first_ray_i    (first_ray_i),
    .last_ray_i     (last_ray_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_valid_o    (hit_valid_o),
    .hit_x_mm_o     (hit_x_mm_o),
    .hit_y_mm_o     (hit_y_mm_o),
    .ray_index_o    (ray_index_o),
    .scan_end_o     (scan_end_o)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Rotates a range by a binary angle with a fixed-point CORDIC and rounds
  // the offsets to whole millimetres.
  function automatic void rotate_range(input logic [RANGE_W-1:0] rng,
                                       input logic [ANGLE_W-1:0] angle,
                                       output longint dx, output longint dy);
    logic [31:0] phase;
    logic [63:0] scaled;
    longint      x, y, z, xs, ys;
    phase  = {angle, 16'h0000} & PH_MASK;
    scaled = 64'(rng) * 64'(GAIN_Q32);
    x = longint'(scaled >> 16);
    y = 0;
    z = longint'($signed(phase));
    // Beyond a quarter turn: start from the opposite vector, half a turn back.
    if (z > QUARTER_TURN || z < -QUARTER_TURN) begin
      x = -x;
      z = longint'($signed(phase + 32'h8000_0000));
    end
    for (int i = 0; i < STEPS_USED; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(atan_turn[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(atan_turn[i]);
      end
    end
    dx = (x + 32768) >>> 16;
    dy = (y + 32768) >>> 16;
  endfunction

  function automatic logic [POS_W-1:0] saturate_pos(input longint v);
    if (v > POS_TOP) return POS_W'(POS_TOP);
    if (v < POS_BOTTOM) return POS_W'(POS_BOTTOM);
    return v[POS_W-1:0];
  endfunction

  // Advances the scan state for one ray and works out its hit word.
  function automatic hit_t project_ray(input ray_t r);
    hit_t   h;
    longint dx, dy;
    if (r.is_first) begin
      ray_pos     = '0;
      ray_heading = scan_angle_start;
    end else begin
      if (ray_pos < RAY_CAP) ray_pos = ray_pos + 1'b1;
      ray_heading = ray_heading + scan_angle_step;
    end
    h.hit_valid = projecting && r.finite && r.rng >= window_low && r.rng <= window_high;
    h.hit_x = '0;
    h.hit_y = '0;
    if (h.hit_valid) begin
      rotate_range(r.rng, ray_heading + robot_yaw, dx, dy);
      h.hit_x = saturate_pos(longint'(robot_x) + dx);
      h.hit_y = saturate_pos(longint'(robot_y) + dy);
    end
    h.index    = ray_pos;
    h.scan_end = r.is_last;
    return h;
  endfunction

  // Mirrors a register write; unknown indexes leave every setting alone.
  function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] data);
    case (idx)
      REG_ANGLE_START: scan_angle_start = data[ANGLE_W-1:0];
      REG_ANGLE_STEP:  scan_angle_step  = data[ANGLE_W-1:0];
      REG_RANGE_LOW:   window_low       = data[RANGE_W-1:0];
      REG_RANGE_HIGH:  window_high      = data[RANGE_W-1:0];
      REG_POSE_X:      robot_x          = data[POS_W-1:0];
      REG_POSE_Y:      robot_y          = data[POS_W-1:0];
      REG_POSE_YAW:    robot_yaw        = data[ANGLE_W-1:0];
      REG_PROJ_ENABLE: projecting       = data[0];
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(input string msg);
    if (mismatch_count < REPORT_LIMIT) $display("%s", msg);
    mismatch_count++;
  endfunction

  // A register value with its extremes favoured; unused upper bits random.
  function automatic logic [CFG_W-1:0] pick_value(input int bits, input bit is_signed);
    logic [CFG_W-1:0] mask;
    logic [CFG_W-1:0] v;
    mask = (CFG_W'(1) << bits) - 1'b1;
    case ($urandom_range(9))
      0:       v = is_signed ? CFG_W'(1) << (bits - 1) : '0;
      1:       v = is_signed ? (CFG_W'(1) << (bits - 1)) - 1'b1 : mask;
      2:       v = '0;
      default: v = CFG_W'($urandom) & mask;
    endcase
    return v | (CFG_W'($urandom) & ~mask);
  endfunction

  // Ranges that often land on or just outside the window edges.
  function automatic logic [RANGE_W-1:0] pick_range_mm();
    case ($urandom_range(9))
      0:       return window_low;
      1:       return window_high;
      2:       return window_low - 1'b1;
      3:       return window_high + 1'b1;
      default: return RANGE_W'($urandom);
    endcase
  endfunction

  // Writes one register; the mirror follows at the same edge.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    apply_setting(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stops offering rays and waits until every hit word has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Offers one ray word after an optional random gap and records its hit.
  task automatic send_ray(input logic [RANGE_W-1:0] rng, input logic finite,
                          input logic is_first, input logic is_last);
    ray_t r;
    r.rng      = rng;
    r.finite   = finite;
    r.is_first = is_first;
    r.is_last  = is_last;
    while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    range_mm_i     <= rng;
    range_finite_i <= finite;
    first_ray_i    <= is_first;
    last_ray_i     <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    pending_hits = {pending_hits, project_ray(r)};
  endtask

  // A well-formed scan: first flag on the opening ray, last on the closing one.
  task automatic send_scan(input int n);
    for (int i = 0; i < n; i++)
      send_ray(pick_range_mm(), $urandom_range(99) < 92, i == 0, i == n - 1);
  endtask

  // Rays with random flags, breaking the scan structure.
  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++)
      send_ray(RANGE_W'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic randomize_settings();
    logic [CFG_W-1:0] lo, hi, swap;
    lo = pick_value(RANGE_W, 1'b0);
    hi = pick_value(RANGE_W, 1'b0);
    // Keep the window mostly the right way round.
    if (lo[RANGE_W-1:0] > hi[RANGE_W-1:0] && $urandom_range(9) != 0) begin
      swap = lo;
      lo   = hi;
      hi   = swap;
    end
    write_register(REG_ANGLE_START, pick_value(ANGLE_W, 1'b1));
    write_register(REG_ANGLE_STEP, pick_value(ANGLE_W, 1'b1));
    write_register(REG_RANGE_LOW, lo);
    write_register(REG_RANGE_HIGH, hi);
    write_register(REG_POSE_X, pick_value(POS_W, 1'b1));
    write_register(REG_POSE_Y, pick_value(POS_W, 1'b1));
    write_register(REG_POSE_YAW, pick_value(ANGLE_W, 1'b1));
    write_register(REG_PROJ_ENABLE,
                   {CFG_W'($urandom) & ~CFG_W'(1)} | CFG_W'($urandom_range(99) < 88));
  endtask

  // Projection is off after reset; a ray without the first flag advances
  // from the reset index and angle.
  task automatic test_reset_values();
    send_ray(16'd1000, 1'b1, 1'b0, 1'b0);
    send_ray(16'd1000, 1'b1, 1'b1, 1'b0);
    send_ray(16'd1000, 1'b1, 1'b0, 1'b1);
  endtask

  // Full-range rays on and around the quarter-turn boundaries.
  task automatic test_quadrant_boundaries();
    wait_idle();
    write_register(REG_PROJ_ENABLE, CFG_W'(1));
    write_register(REG_POSE_X, '0);
    write_register(REG_POSE_Y, '0);
    write_register(REG_POSE_YAW, '0);
    write_register(REG_RANGE_LOW, '0);
    write_register(REG_RANGE_HIGH, CFG_W'(16'hFFFF));
    write_register(REG_ANGLE_START, '0);
    write_register(REG_ANGLE_STEP, CFG_W'(16'h4000));
    send_scan(0);
    for (int i = 0; i < 4; i++) send_ray(16'hFFFF, 1'b1, i == 0, i == 3);
    wait_idle();
    write_register(REG_ANGLE_START, CFG_W'(16'h3FFF));
    write_register(REG_ANGLE_STEP, CFG_W'(16'h0001));
    for (int i = 0; i < 3; i++) send_ray(16'hFFFF, 1'b1, i == 0, i == 2);
    // Same scan seen through a yaw of half a turn.
    wait_idle();
    write_register(REG_POSE_YAW, CFG_W'(16'h8000));
    for (int i = 0; i < 3; i++) send_ray(16'hFFFF, 1'b1, i == 0, i == 2);
    wait_idle();
    write_register(REG_POSE_YAW, CFG_W'(16'h7FFF));
    write_register(REG_ANGLE_START, CFG_W'(16'h7FFF));
    write_register(REG_ANGLE_STEP, CFG_W'(16'h8000));
    send_ray(16'hFFFF, 1'b1, 1'b1, 1'b0);
    send_ray(16'hFFFF, 1'b1, 1'b0, 1'b1);
  endtask

  // Window edges, a non-finite ray, a zero range and an inverted window.
  task automatic test_range_window();
    wait_idle();
    write_register(REG_POSE_YAW, '0);
    write_register(REG_ANGLE_STEP, CFG_W'(16'h0123));
    write_register(REG_RANGE_LOW, CFG_W'(100));
    write_register(REG_RANGE_HIGH, CFG_W'(200));
    send_ray(16'd99, 1'b1, 1'b1, 1'b0);
    send_ray(16'd100, 1'b1, 1'b0, 1'b0);
    send_ray(16'd200, 1'b1, 1'b0, 1'b0);
    send_ray(16'd201, 1'b1, 1'b0, 1'b0);
    send_ray(16'd150, 1'b0, 1'b0, 1'b1);
    wait_idle();
    write_register(REG_RANGE_LOW, '0);
    send_ray(16'd0, 1'b1, 1'b1, 1'b0);
    wait_idle();
    write_register(REG_RANGE_LOW, CFG_W'(300));
    send_ray(16'd250, 1'b1, 1'b0, 1'b1);
    wait_idle();
    write_register(REG_RANGE_LOW, CFG_W'(16'hFFFF));
    write_register(REG_RANGE_HIGH, CFG_W'(16'hFFFF));
    send_ray(16'hFFFF, 1'b1, 1'b0, 1'b1);
  endtask

  // Pose at the position extremes pushes both sums past the 24-bit range.
  task automatic test_saturation();
    wait_idle();
    write_register(REG_RANGE_LOW, '0);
    write_register(REG_POSE_X, CFG_W'(24'h7F_FFFF));
    write_register(REG_POSE_Y, CFG_W'(24'h80_0000));
    write_register(REG_ANGLE_START, '0);
    write_register(REG_ANGLE_STEP, CFG_W'(16'hC000));
    send_ray(16'hFFFF, 1'b1, 1'b1, 1'b0);
    send_ray(16'hFFFF, 1'b1, 1'b0, 1'b1);
  endtask

  // Writes to indexes past the last register must change nothing.
  task automatic test_unknown_register();
    wait_idle();
    for (int i = NUM_REGS; i < (1 << CFG_IDX_W); i++)
      write_register(CFG_IDX_W'(i), CFG_W'($urandom));
    send_ray(16'd4000, 1'b1, 1'b1, 1'b0);
    send_ray(16'd4000, 1'b1, 1'b0, 1'b1);
  endtask

  // One long scan sent with no idling, so the ray index climbs steadily.
  task automatic test_long_scan();
    wait_idle();
    randomize_settings();
    steady_flow = 1'b1;
    send_scan(LONG_SCAN_RAYS);
    steady_flow = 1'b0;
  endtask

  // The receiver holds off while rays keep coming, so the input stalls.
  task automatic test_back_pressure();
    wait_idle();
    hold_off_request = HOLD_OFF_CYCLES;
    send_scan(12);
  endtask

  // Random settings per phase, mostly well-formed scans plus some noise.
  task automatic test_random_scans();
    int sent;
    int phase;
    int burst;
    int n;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_RAYS) begin
      wait_idle();
      randomize_settings();
      steady_flow = (phase == 2);
      burst = 0;
      while (burst < 150) begin
        if ($urandom_range(99) < 80) begin
          n = ($urandom_range(9) == 0) ? $urandom_range(200, 25) : $urandom_range(24, 1);
          send_scan(n);
        end else begin
          n = $urandom_range(8, 1);
          send_noise(n);
        end
        burst += n;
      end
      steady_flow = 1'b0;
      sent += burst;
      phase++;
    end
  endtask

  // Receiver: random stalls, steady stretches and requested long hold-offs.
  always begin
    @(posedge clk_i);
    if (hold_off_request != 0) begin
      hold_span        = hold_off_request;
      hold_off_request = 0;
      out_ready_i <= 1'b0;
      repeat (hold_span) @(posedge clk_i);
    end
    if (steady_flow) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Compares every accepted hit word with the oldest expected one.
  always @(posedge clk_i) begin : check_hits
    hit_t  got;
    hit_t  want;
    string bad;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {hit_valid_o, hit_x_mm_o, hit_y_mm_o, ray_index_o, scan_end_o};
      if (pending_hits.size() == 0) begin
        note_mismatch($sformatf("unexpected hit word: valid=%0b x=%0d y=%0d index=%0d end=%0b",
                                got.hit_valid, $signed(got.hit_x), $signed(got.hit_y),
                                got.index, got.scan_end));
      end else begin
        want = pending_hits.pop_front();
        bad  = "";
        if (got.hit_valid !== want.hit_valid) bad = {bad, " hit_valid"};
        if (got.hit_x !== want.hit_x) bad = {bad, " hit_x_mm"};
        if (got.hit_y !== want.hit_y) bad = {bad, " hit_y_mm"};
        if (got.index !== want.index) bad = {bad, " ray_index"};
        if (got.scan_end !== want.scan_end) bad = {bad, " scan_end"};
        if (bad != "")
          note_mismatch($sformatf({"word %0d wrong in%s: expected valid=%0b x=%0d y=%0d ",
                                   "index=%0d end=%0b, got valid=%0b x=%0d y=%0d ",
                                   "index=%0d end=%0b"},
                                  checked_words, bad, want.hit_valid, $signed(want.hit_x),
                                  $signed(want.hit_y), want.index, want.scan_end,
                                  got.hit_valid, $signed(got.hit_x), $signed(got.hit_y),
                                  got.index, got.scan_end));
      end
      checked_words++;
    end
  end

  // Test sequence.
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    range_mm_i     = '0;
    range_finite_i = 1'b0;
    first_ray_i    = 1'b0;
    last_ray_i     = 1'b0;
    out_ready_i    = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_quadrant_boundaries();
    test_range_window();
    test_saturation();
    test_unknown_register();
    test_back_pressure();
    test_long_scan();
    test_random_scans();
    wait_idle();
    if (mismatch_count == 0 && pending_hits.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
